### sv/dvfs_pkg.sv
// Package for the DVFS clock-switch sequencer: widths, codes, the operating-point ROM
// and the microprogram that drives the sequencer. No dependencies.
`default_nettype none

package dvfs_pkg;

	localparam int ROM_SIZE      = 23;
	localparam int TABLE_ENTRIES = 23;
	localparam int N_SEARCH      = (TABLE_ENTRIES < ROM_SIZE) ? TABLE_ENTRIES : ROM_SIZE;

	localparam int IDX_W = 5;
	localparam int KHZ_W = 21;
	localparam int MV_W  = 11;
	localparam int BUS_W = 17;
	localparam int L_W   = 6;
	localparam int CFG_W = 8;
	localparam int UPC_W = 4;
	localparam int REG_W = 2;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [KHZ_W-1:0] khz_t;
	typedef logic [UPC_W-1:0] upc_t;
	typedef logic [REG_W-1:0] reg_idx_t;
	typedef logic [1:0]       cmd_t;
	typedef logic [1:0]       reason_t;
	typedef logic [1:0]       status_t;

	localparam idx_t RESET_INDEX   = 5'd14;
	localparam idx_t STANDBY_ENTRY = 5'd2;
	localparam idx_t LAST_ENTRY    = IDX_W'(ROM_SIZE - 1);
	localparam idx_t LAST_SEARCH   = IDX_W'(N_SEARCH - 1);
	localparam khz_t RESET_KHZ     = 21'd245000;

	localparam logic [L_W-1:0] L_MIN  = 6'd10;
	localparam logic [L_W-1:0] L_MAX  = 6'd33;
	localparam logic [L_W-1:0] L_SHOT = 6'h0A;

	localparam cmd_t CMD_SET_RATE = 2'd0;
	localparam cmd_t CMD_COLLAPSE = 2'd1;
	localparam cmd_t CMD_WAIT_IRQ = 2'd2;

	localparam reason_t REASON_CPUFREQ       = 2'd0;
	localparam reason_t REASON_WAIT_IRQ      = 2'd1;
	localparam reason_t REASON_COLLAPSE      = 2'd2;
	localparam reason_t REASON_COLLAPSE_IDLE = 2'd3;

	localparam status_t ST_SWITCHED  = 2'd0;
	localparam status_t ST_NO_CHANGE = 2'd1;
	localparam status_t ST_NOT_FOUND = 2'd2;

	localparam reg_idx_t REG_COLLAPSE_KHZ = 2'd0;
	localparam reg_idx_t REG_WAIT_IRQ_KHZ = 2'd1;
	localparam reg_idx_t REG_STANDBY_KHZ  = 2'd2;
	localparam reg_idx_t REG_VDD_ENABLE   = 2'd3;

	typedef enum logic [1:0] {
		SRC_RAW = 2'd0,
		SRC_PLL = 2'd1,
		SRC_AXI = 2'd2
	} src_t;

	typedef enum logic [2:0] {
		ACT_DONE      = 3'd0,
		ACT_SET_VDD   = 3'd1,
		ACT_SEL_CLOCK = 3'd2,
		ACT_PLL_SHOT  = 3'd3,
		ACT_PLL_HOP   = 3'd4,
		ACT_PLL_OFF   = 3'd5,
		ACT_BUS_RATE  = 3'd6
	} action_t;

	typedef struct packed {
		khz_t             khz;
		logic [CFG_W-1:0] cfg;
		src_t             sel;
		logic [L_W-1:0]   lval;
		logic [MV_W-1:0]  mv;
		logic [BUS_W-1:0] bus;
	} op_point_t;

	// Operating-point ROM; an index beyond the table reads the last entry.
	function automatic op_point_t rom_point(input idx_t idx);
		op_point_t p;
		case (idx)
			5'd0:  p = '{21'd19200,   8'h00, SRC_RAW, 6'h00, 11'd975,  17'd14000};
			5'd1:  p = '{21'd128000,  8'h00, SRC_AXI, 6'h00, 11'd975,  17'd14000};
			5'd2:  p = '{21'd245000,  8'h40, SRC_RAW, 6'h00, 11'd1025, 17'd29000};
			5'd3:  p = '{21'd384000,  8'h00, SRC_PLL, 6'h0A, 11'd1025, 17'd58000};
			5'd4:  p = '{21'd422400,  8'h00, SRC_PLL, 6'h0B, 11'd1050, 17'd117000};
			5'd5:  p = '{21'd460800,  8'h00, SRC_PLL, 6'h0C, 11'd1050, 17'd117000};
			5'd6:  p = '{21'd499200,  8'h00, SRC_PLL, 6'h0D, 11'd1075, 17'd117000};
			5'd7:  p = '{21'd537600,  8'h00, SRC_PLL, 6'h0E, 11'd1075, 17'd117000};
			5'd8:  p = '{21'd576000,  8'h00, SRC_PLL, 6'h0F, 11'd1100, 17'd117000};
			5'd9:  p = '{21'd614400,  8'h00, SRC_PLL, 6'h10, 11'd1100, 17'd117000};
			5'd10: p = '{21'd652800,  8'h00, SRC_PLL, 6'h11, 11'd1125, 17'd117000};
			5'd11: p = '{21'd691200,  8'h00, SRC_PLL, 6'h12, 11'd1150, 17'd117000};
			5'd12: p = '{21'd729600,  8'h00, SRC_PLL, 6'h13, 11'd1175, 17'd117000};
			5'd13: p = '{21'd768000,  8'h00, SRC_PLL, 6'h14, 11'd1200, 17'd128000};
			5'd14: p = '{21'd806400,  8'h00, SRC_PLL, 6'h15, 11'd1225, 17'd128000};
			5'd15: p = '{21'd844800,  8'h00, SRC_PLL, 6'h16, 11'd1250, 17'd128000};
			5'd16: p = '{21'd883200,  8'h00, SRC_PLL, 6'h17, 11'd1275, 17'd128000};
			5'd17: p = '{21'd921600,  8'h00, SRC_PLL, 6'h18, 11'd1275, 17'd128000};
			5'd18: p = '{21'd960000,  8'h00, SRC_PLL, 6'h19, 11'd1275, 17'd128000};
			5'd19: p = '{21'd998400,  8'h00, SRC_PLL, 6'h1A, 11'd1275, 17'd128000};
			5'd20: p = '{21'd1036800, 8'h00, SRC_PLL, 6'h1B, 11'd1275, 17'd128000};
			5'd21: p = '{21'd1075200, 8'h00, SRC_PLL, 6'h1C, 11'd1275, 17'd128000};
			default: p = '{21'd1113600, 8'h00, SRC_PLL, 6'h1D, 11'd1275, 17'd128000};
		endcase
		return p;
	endfunction

	// Rate of an entry, with the standby entry taken from its register.
	function automatic khz_t khz_of(input idx_t idx, input khz_t standby_khz);
		op_point_t p;
		p = rom_point(idx);
		return (idx == STANDBY_ENTRY) ? standby_khz : p.khz;
	endfunction

	// Microcode fields.
	typedef enum logic [1:0] {
		OP_WAIT   = 2'd0,
		OP_CHECK  = 2'd1,
		OP_SEARCH = 2'd2,
		OP_EMIT   = 2'd3
	} uop_t;

	typedef enum logic [2:0] {
		ARG_ZERO    = 3'd0,
		ARG_NX_MV   = 3'd1,
		ARG_STB_SEL = 3'd2,
		ARG_NX_SEL  = 3'd3,
		ARG_PLL_SEL = 3'd4,
		ARG_SHOT    = 3'd5,
		ARG_HOP     = 3'd6,
		ARG_BUS     = 3'd7
	} argsel_t;

	typedef enum logic [2:0] {
		C_ALWAYS      = 3'd0,
		C_VDD_UP      = 3'd1,
		C_VDD_DOWN    = 3'd2,
		C_NOT_STANDBY = 3'd3,
		C_PLL_STOPPED = 3'd4,
		C_CUR_PLL     = 3'd5,
		C_BUS_DIFF    = 3'd6
	} cond_t;

	typedef enum logic [1:0] {
		J_NEXT       = 2'd0,
		J_ALWAYS     = 2'd1,
		J_NX_NOT_PLL = 2'd2
	} jump_t;

	typedef struct packed {
		uop_t    op;
		action_t act;
		argsel_t arg;
		cond_t   cond;
		jump_t   jump;
		upc_t    target;
		logic    set_pll;
		logic    clr_pll;
		logic    commit;
		logic    fin;
	} uword_t;

	typedef struct packed {
		logic emit_ok;
		logic nx_pll;
		khz_t arg;
	} dp_out_t;

	localparam upc_t STEP_WAIT    = 4'd0;
	localparam upc_t STEP_CHECK   = 4'd1;
	localparam upc_t STEP_SEARCH  = 4'd2;
	localparam upc_t STEP_VDD_UP  = 4'd3;
	localparam upc_t STEP_PLL_STB = 4'd4;
	localparam upc_t STEP_SHOT    = 4'd5;
	localparam upc_t STEP_HOP     = 4'd6;
	localparam upc_t STEP_PLL_SEL = 4'd7;
	localparam upc_t STEP_NP_STB  = 4'd8;
	localparam upc_t STEP_NP_SEL  = 4'd9;
	localparam upc_t STEP_NP_OFF  = 4'd10;
	localparam upc_t STEP_BUS     = 4'd11;
	localparam upc_t STEP_VDD_DN  = 4'd12;
	localparam upc_t STEP_DONE    = 4'd13;

	// The switching program, one control word per step.
	function automatic uword_t ucode(input upc_t pc);
		uword_t w;
		case (pc)
			STEP_CHECK:   w = '{OP_CHECK, ACT_DONE, ARG_ZERO, C_ALWAYS, J_NEXT,
				STEP_WAIT, 1'b0, 1'b0, 1'b0, 1'b0};
			STEP_SEARCH:  w = '{OP_SEARCH, ACT_DONE, ARG_ZERO, C_ALWAYS, J_NEXT,
				STEP_WAIT, 1'b0, 1'b0, 1'b0, 1'b0};
			STEP_VDD_UP:  w = '{OP_EMIT, ACT_SET_VDD, ARG_NX_MV, C_VDD_UP, J_NX_NOT_PLL,
				STEP_NP_STB, 1'b0, 1'b0, 1'b0, 1'b0};
			STEP_PLL_STB: w = '{OP_EMIT, ACT_SEL_CLOCK, ARG_STB_SEL, C_NOT_STANDBY, J_NEXT,
				STEP_WAIT, 1'b0, 1'b0, 1'b0, 1'b0};
			STEP_SHOT:    w = '{OP_EMIT, ACT_PLL_SHOT, ARG_SHOT, C_PLL_STOPPED, J_NEXT,
				STEP_WAIT, 1'b0, 1'b0, 1'b0, 1'b0};
			STEP_HOP:     w = '{OP_EMIT, ACT_PLL_HOP, ARG_HOP, C_ALWAYS, J_NEXT,
				STEP_WAIT, 1'b1, 1'b0, 1'b0, 1'b0};
			STEP_PLL_SEL: w = '{OP_EMIT, ACT_SEL_CLOCK, ARG_PLL_SEL, C_ALWAYS, J_ALWAYS,
				STEP_BUS, 1'b0, 1'b0, 1'b0, 1'b0};
			STEP_NP_STB:  w = '{OP_EMIT, ACT_SEL_CLOCK, ARG_STB_SEL, C_CUR_PLL, J_NEXT,
				STEP_WAIT, 1'b0, 1'b0, 1'b0, 1'b0};
			STEP_NP_SEL:  w = '{OP_EMIT, ACT_SEL_CLOCK, ARG_NX_SEL, C_ALWAYS, J_NEXT,
				STEP_WAIT, 1'b0, 1'b0, 1'b0, 1'b0};
			STEP_NP_OFF:  w = '{OP_EMIT, ACT_PLL_OFF, ARG_ZERO, C_CUR_PLL, J_NEXT,
				STEP_WAIT, 1'b0, 1'b1, 1'b0, 1'b0};
			STEP_BUS:     w = '{OP_EMIT, ACT_BUS_RATE, ARG_BUS, C_BUS_DIFF, J_NEXT,
				STEP_WAIT, 1'b0, 1'b0, 1'b1, 1'b0};
			STEP_VDD_DN:  w = '{OP_EMIT, ACT_SET_VDD, ARG_NX_MV, C_VDD_DOWN, J_NEXT,
				STEP_WAIT, 1'b0, 1'b0, 1'b0, 1'b0};
			STEP_DONE:    w = '{OP_EMIT, ACT_DONE, ARG_ZERO, C_ALWAYS, J_ALWAYS,
				STEP_WAIT, 1'b0, 1'b0, 1'b0, 1'b1};
			default:      w = '{OP_WAIT, ACT_DONE, ARG_ZERO, C_ALWAYS, J_NEXT,
				STEP_WAIT, 1'b0, 1'b0, 1'b0, 1'b0};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

### sv/dvfs_req_if.sv
// Request channel of the DVFS sequencer: valid/ready handshake and request payload.
// Depends on dvfs_pkg.
`default_nettype none

interface dvfs_req_if import dvfs_pkg::*; ();
	logic    valid;
	logic    ready;
	cmd_t    command;
	khz_t    target_khz;
	reason_t reason;
	logic    idle_collapse;

	modport source (output valid, command, target_khz, reason, idle_collapse, input ready);
	modport sink (input valid, command, target_khz, reason, idle_collapse, output ready);
endinterface

`default_nettype wire

### sv/dvfs_act_if.sv
// Action channel of the DVFS sequencer: valid/ready handshake and action payload.
// Depends on dvfs_pkg.
`default_nettype none

interface dvfs_act_if import dvfs_pkg::*; ();
	logic    valid;
	logic    ready;
	action_t action;
	khz_t    argument;
	status_t status;
	khz_t    previous_khz;
	logic    last;

	modport source (output valid, action, argument, status, previous_khz, last, input ready);
	modport sink (input valid, action, argument, status, previous_khz, last, output ready);
endinterface

`default_nettype wire

### sv/dvfs_clock_switch_sequencer_core.sv
// Top level of the DVFS clock-switch sequencer: microcoded control over the operating-point
// ROM. Depends on dvfs_pkg, dvfs_req_if, dvfs_act_if and dvfs_datapath.
`default_nettype none

// Channel   Dir  Handshake       Payload
// req       in   valid / ready   command, target_khz, reason, idle_collapse
// act       out  valid / ready   action, argument, status, previous_khz, last
// cfg       in   cfg_we          cfg_index, cfg_data (write only, no stall)
//
// One request is handled at a time. An accepted request moves to the check step and then to
// the rate search, which visits ROM entries in order (up to 23). A rate that is found then
// walks eight program steps on the PLL path or seven off it, whether or not each step emits;
// a rate missing from the table and a request that causes no change go to the done step.
// Reset puts the core at the 806400 kHz entry with the PLL running and the registers at
// their documented values. A stalled action output holds the step counter at the next
// step that emits; the output register is reloaded in the cycle its action is taken, so
// unstalled actions follow back to back.

module dvfs_clock_switch_sequencer_core import dvfs_pkg::*; (
	input  wire              clk,
	input  wire              arst_n,
	dvfs_req_if.sink         req,
	dvfs_act_if.source       act,
	input  wire              cfg_we,
	input  wire [REG_W-1:0]  cfg_index,
	input  wire [KHZ_W-1:0]  cfg_data
);

	// Configuration registers.
	khz_t collapse_khz_q;
	khz_t wait_irq_khz_q;
	khz_t standby_khz_q;
	logic vdd_en_q;

	// Sequencer state.
	upc_t    upc_q;
	idx_t    current_index_q;
	logic    pll_running_q;

	// Per-request context; ni_q and status_q are set later, the rest on accept.
	idx_t    ci_q;
	idx_t    ni_q;
	reason_t why_q;
	khz_t    rate_q;
	khz_t    prev_q;
	logic    need_drop_q;
	status_t status_q;

	// Output register.
	logic    act_valid_q;
	action_t act_action_q;
	khz_t    act_arg_q;
	status_t act_status_q;
	khz_t    act_prev_q;
	logic    act_last_q;

	uword_t  uw;
	dp_out_t dp;
	idx_t    cur_entry;
	khz_t    rate_d;
	reason_t why_d;
	logic    out_free;
	logic    emit_now;
	logic    no_change;
	upc_t    upc_next;

	assign uw = ucode(upc_q);

	// A stale index would read the last entry; keep the same guard here.
	assign cur_entry = (current_index_q > LAST_ENTRY) ? LAST_ENTRY : current_index_q;

	dvfs_datapath u_datapath (
		.uw          (uw),
		.cur_idx     (ci_q),
		.nx_idx      (ni_q),
		.why         (why_q),
		.vdd_en      (vdd_en_q),
		.pll_running (pll_running_q),
		.dp          (dp)
	);

	// Target rate and reason for each command. The unused command code gets a rate of
	// zero, which the check step turns into a no-change result.
	always_comb begin
		case (req.command)
			CMD_SET_RATE: begin
				rate_d = req.target_khz;
				why_d  = req.reason;
			end
			CMD_COLLAPSE: begin
				rate_d = collapse_khz_q;
				why_d  = req.idle_collapse ? REASON_COLLAPSE_IDLE : REASON_COLLAPSE;
			end
			CMD_WAIT_IRQ: begin
				rate_d = wait_irq_khz_q;
				why_d  = REASON_WAIT_IRQ;
			end
			default: begin
				rate_d = '0;
				why_d  = REASON_CPUFREQ;
			end
		endcase
	end

	// Collapse and wait requests only switch when the current rate is above the target.
	assign no_change = (rate_q == '0) || (rate_q == khz_of(ci_q, standby_khz_q))
		|| (need_drop_q && !(prev_q > rate_q));

	assign out_free = !act_valid_q || act.ready;

	// An action is loaded into the output register in this cycle.
	assign emit_now = (uw.op == OP_EMIT) && dp.emit_ok && out_free;

	always_comb begin
		case (uw.jump)
			J_ALWAYS:     upc_next = uw.target;
			J_NX_NOT_PLL: upc_next = dp.nx_pll ? upc_t'(upc_q + 1'b1) : uw.target;
			default:      upc_next = upc_t'(upc_q + 1'b1);
		endcase
	end

	assign req.ready        = (upc_q == STEP_WAIT);
	assign act.valid        = act_valid_q;
	assign act.action       = act_action_q;
	assign act.argument     = act_arg_q;
	assign act.status       = act_status_q;
	assign act.previous_khz = act_prev_q;
	assign act.last         = act_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collapse_khz_q <= RESET_KHZ;
			wait_irq_khz_q <= RESET_KHZ;
			standby_khz_q  <= RESET_KHZ;
			vdd_en_q       <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COLLAPSE_KHZ: collapse_khz_q <= cfg_data;
				REG_WAIT_IRQ_KHZ: wait_irq_khz_q <= cfg_data;
				REG_STANDBY_KHZ:  standby_khz_q  <= cfg_data;
				REG_VDD_ENABLE:   vdd_en_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Step counter, core state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q           <= STEP_WAIT;
			current_index_q <= RESET_INDEX;
			pll_running_q   <= 1'b1;
			act_valid_q     <= 1'b0;
		end else begin
			if (emit_now) begin
				act_valid_q <= 1'b1;
			end else if (act.ready) begin
				act_valid_q <= 1'b0;
			end
			case (uw.op)
				OP_WAIT: begin
					if (req.valid) begin
						ci_q        <= cur_entry;
						why_q       <= why_d;
						rate_q      <= rate_d;
						prev_q      <= khz_of(cur_entry, standby_khz_q);
						need_drop_q <= (req.command == CMD_COLLAPSE)
							|| (req.command == CMD_WAIT_IRQ);
						upc_q       <= STEP_CHECK;
					end
				end
				OP_CHECK: begin
					ni_q <= '0;
					if (no_change) begin
						status_q <= ST_NO_CHANGE;
						upc_q    <= STEP_DONE;
					end else begin
						upc_q <= STEP_SEARCH;
					end
				end
				OP_SEARCH: begin
					// First matching entry wins; the index stays on it when found.
					if (khz_of(ni_q, standby_khz_q) == rate_q) begin
						status_q <= ST_SWITCHED;
						upc_q    <= STEP_VDD_UP;
					end else if (ni_q == LAST_SEARCH) begin
						status_q <= ST_NOT_FOUND;
						upc_q    <= STEP_DONE;
					end else begin
						ni_q <= idx_t'(ni_q + 1'b1);
					end
				end
				OP_EMIT: begin
					// A step whose condition fails passes without an action.
					if (!dp.emit_ok || out_free) begin
						upc_q <= upc_next;
						if (uw.commit) begin
							current_index_q <= ni_q;
						end
						if (dp.emit_ok && uw.set_pll) begin
							pll_running_q <= 1'b1;
						end
						if (dp.emit_ok && uw.clr_pll) begin
							pll_running_q <= 1'b0;
						end
						if (dp.emit_ok) begin
							act_action_q <= uw.act;
							act_arg_q    <= dp.arg;
							act_status_q <= uw.fin ? status_q : ST_SWITCHED;
							act_prev_q   <= uw.fin ? prev_q : '0;
							act_last_q   <= uw.fin;
						end
					end
				end
				default: upc_q <= STEP_WAIT;
			endcase
		end
	end

`ifndef SYNTH
	a_req_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> upc_q == STEP_CHECK)
		else $error("accepted request did not move to the check step");

	a_search_bound: assert property (@(posedge clk) disable iff (!arst_n)
		upc_q == STEP_SEARCH |-> ni_q <= LAST_SEARCH)
		else $error("rate search ran past the searched entries");

	a_index_in_rom: assert property (@(posedge clk) disable iff (!arst_n)
		current_index_q <= LAST_ENTRY)
		else $error("current operating point outside the ROM");

	a_pll_up_before_select: assert property (@(posedge clk) disable iff (!arst_n)
		upc_q == STEP_PLL_SEL |-> pll_running_q)
		else $error("PLL selected while not marked running");

	a_plain_action_fields: assert property (@(posedge clk) disable iff (!arst_n)
		act.valid && act.action != ACT_DONE |->
		act.status == ST_SWITCHED && act.previous_khz == '0 && !act.last)
		else $error("non-final action carries done fields");
`endif

endmodule

`default_nettype wire

### sv/dvfs_datapath.sv
// Datapath of the DVFS sequencer: evaluates the step condition and forms the action
// argument from the current and next operating points. Depends on dvfs_pkg.
`default_nettype none

module dvfs_datapath import dvfs_pkg::*; (
	input  uword_t  uw,
	input  idx_t    cur_idx,
	input  idx_t    nx_idx,
	input  reason_t why,
	input  logic    vdd_en,
	input  logic    pll_running,
	output dp_out_t dp
);

	op_point_t      cur;
	op_point_t      nx;
	op_point_t      stb;
	logic [L_W-1:0] hop_l;
	logic           cond_ok;
	logic           cpufreq;

	assign cur     = rom_point(cur_idx);
	assign nx      = rom_point(nx_idx);
	assign stb     = rom_point(STANDBY_ENTRY);
	assign cpufreq = (why == REASON_CPUFREQ) && vdd_en;

	always_comb begin
		if (nx.lval > L_MAX) begin
			hop_l = L_MAX;
		end else if (nx.lval < L_MIN) begin
			hop_l = L_MIN;
		end else begin
			hop_l = nx.lval;
		end
	end

	always_comb begin
		case (uw.cond)
			C_ALWAYS:      cond_ok = 1'b1;
			C_VDD_UP:      cond_ok = cpufreq && (nx.mv > cur.mv);
			C_VDD_DOWN:    cond_ok = cpufreq && (nx.mv < cur.mv);
			C_NOT_STANDBY: cond_ok = !((cur.cfg == stb.cfg) && (cur.sel == stb.sel));
			C_PLL_STOPPED: cond_ok = !pll_running;
			C_CUR_PLL:     cond_ok = (cur.sel == SRC_PLL);
			C_BUS_DIFF:    cond_ok = ((why == REASON_CPUFREQ) || (why == REASON_COLLAPSE))
				&& (cur.bus != nx.bus);
			default:       cond_ok = 1'b0;
		endcase
	end

	always_comb begin
		dp.emit_ok = cond_ok;
		dp.nx_pll  = (nx.sel == SRC_PLL);
		case (uw.arg)
			ARG_NX_MV:   dp.arg = KHZ_W'(nx.mv);
			ARG_STB_SEL: dp.arg = KHZ_W'({stb.sel, stb.cfg});
			ARG_NX_SEL:  dp.arg = KHZ_W'({nx.sel, nx.cfg});
			ARG_PLL_SEL: dp.arg = KHZ_W'({SRC_PLL, {CFG_W{1'b0}}});
			ARG_SHOT:    dp.arg = KHZ_W'(L_SHOT);
			ARG_HOP:     dp.arg = KHZ_W'(hop_l);
			ARG_BUS:     dp.arg = KHZ_W'(nx.bus);
			default:     dp.arg = '0;
		endcase
	end

endmodule

`default_nettype wire
